// File: src/tep_pkg.sv
// Shared constants and types for the tab expansion and page fill block.
package tep_pkg;

	// Column and line counter width
	localparam int COUNTER_WIDTH = 16;

	// Character codes
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_FORM_FEED = 8'd12;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	// Configuration register indexes
	localparam logic [1:0] CFG_FIRST_TAB_WIDTH = 2'd0;
	localparam logic [1:0] CFG_TAB_WIDTH       = 2'd1;
	localparam logic [1:0] CFG_PAGE_LENGTH     = 2'd2;

	// Configuration reset values
	localparam logic [7:0]  RST_FIRST_TAB_WIDTH = 8'd8;
	localparam logic [7:0]  RST_TAB_WIDTH       = 8'd8;
	localparam logic [15:0] RST_PAGE_LENGTH     = 16'd66;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

// File: src/tep_rem_unit.sv
// Bit-serial restoring remainder unit: column modulo tab width, one bit per cycle.
module tep_rem_unit #(
	parameter int COUNTER_WIDTH = tep_pkg::COUNTER_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COUNTER_WIDTH-1:0] dividend,
	input  logic [7:0]               divisor,
	output tep_pkg::rem_stat_t       stat,
	output logic [7:0]               remainder
);

	localparam int CNT_W = $clog2(COUNTER_WIDTH + 1);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [COUNTER_WIDTH-1:0] shift_q;
	logic [7:0]               rem_q;
	logic [8:0]               trial;
	logic [8:0]               rem_next;

	// Shift in the next dividend bit and subtract the divisor if it fits
	always_comb begin
		trial = {rem_q, shift_q[COUNTER_WIDTH-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial - {1'b0, divisor};
		end else begin
			rem_next = trial;
		end
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(COUNTER_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Hold the partial remainder and the remaining dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			rem_q   <= rem_next[7:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// File: src/tab_expand_page_fill_core.sv
// Top level: tab expansion with page fill, column and line counters, output register.
//
//   channel  direction  signals                        payload
//   in       input      in_valid, in_stall             in_byte
//   out      output     out_valid, out_stall           out_byte, repeat_count
//   cfg      input      cfg_we, cfg_index, cfg_data    first_tab_width, tab_width, page_length
//
// A tab waits in the divide state for the bit-serial remainder unit before it
// reaches the finish state; every other byte goes straight from idle to finish.
// Reset clears both counters and loads the register defaults.
// in_stall is high while an item is in work; a stalled output holds the
// finished item in the sequencer until the output register frees up.
module tab_expand_page_fill_core #(
	parameter int COUNTER_WIDTH = tep_pkg::COUNTER_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] repeat_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	tep_pkg::state_t          state_q;
	tep_pkg::state_t          state_nxt;
	tep_pkg::rem_stat_t       rem_stat;

	logic [7:0]               first_tab_q;
	logic [7:0]               tab_width_q;
	logic [15:0]              page_len_q;
	logic [COUNTER_WIDTH-1:0] col_q;
	logic [COUNTER_WIDTH-1:0] line_q;
	logic [7:0]               byte_q;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic [15:0]              out_count_q;

	logic                     in_xfer;
	logic                     rem_start;
	logic                     commit;
	logic [COUNTER_WIDTH-1:0] col_inc;
	logic [7:0]               tab_w;
	logic [7:0]               rem;
	logic [7:0]               pad;
	logic [COUNTER_WIDTH:0]   col_sum;
	logic [LW-1:0]            page_ext;
	logic [LW-1:0]            line_ext;
	logic [LW-1:0]            ff_diff;
	logic [7:0]               res_byte;
	logic [15:0]              res_count;
	logic [COUNTER_WIDTH-1:0] col_nxt;
	logic [COUNTER_WIDTH-1:0] line_nxt;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_tab_q <= tep_pkg::RST_FIRST_TAB_WIDTH;
			tab_width_q <= tep_pkg::RST_TAB_WIDTH;
			page_len_q  <= tep_pkg::RST_PAGE_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				tep_pkg::CFG_FIRST_TAB_WIDTH: first_tab_q <= cfg_data[7:0];
				tep_pkg::CFG_TAB_WIDTH:       tab_width_q <= cfg_data[7:0];
				tep_pkg::CFG_PAGE_LENGTH:     page_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Treat a zero tab width as one
	assign tab_w   = (tab_width_q == 8'd0) ? 8'd1 : tab_width_q;
	assign col_inc = (col_q == CNT_MAX) ? col_q : col_q + 1'b1;
	assign in_xfer = in_valid && !in_stall;

	// Column modulo tab width
	tep_rem_unit #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (col_inc),
		.divisor  (tab_w),
		.stat     (rem_stat),
		.remainder(rem)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tep_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_byte == tep_pkg::CHAR_TAB) ? tep_pkg::ST_DIVIDE
					                                           : tep_pkg::ST_FINISH;
				end
			end
			tep_pkg::ST_DIVIDE: begin
				if (rem_stat.done) begin
					state_nxt = tep_pkg::ST_FINISH;
				end
			end
			tep_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = tep_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tep_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = (state_q != tep_pkg::ST_IDLE);
		rem_start = (state_q == tep_pkg::ST_IDLE) && in_valid && (in_byte == tep_pkg::CHAR_TAB);
		commit    = (state_q == tep_pkg::ST_FINISH) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tep_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Form the result and the counter updates for the held byte
	always_comb begin
		page_ext  = LW'(page_len_q);
		line_ext  = LW'(line_q);
		ff_diff   = page_ext - line_ext;
		if (col_q < COUNTER_WIDTH'(first_tab_q)) begin
			pad = first_tab_q - col_q[7:0];
		end else if (rem == 8'd0) begin
			pad = 8'd0;
		end else begin
			pad = tab_w - rem;
		end
		col_sum   = {1'b0, col_q} + (COUNTER_WIDTH + 1)'(pad);
		res_byte  = byte_q;
		res_count = 16'd1;
		col_nxt   = col_q;
		line_nxt  = line_q;
		case (byte_q)
			tep_pkg::CHAR_NEWLINE: begin
				col_nxt  = '0;
				line_nxt = (line_q == CNT_MAX) ? line_q : line_q + 1'b1;
			end
			tep_pkg::CHAR_TAB: begin
				res_byte  = tep_pkg::CHAR_SPACE;
				res_count = 16'(pad) + 16'd1;
				col_nxt   = col_sum[COUNTER_WIDTH] ? CNT_MAX : col_sum[COUNTER_WIDTH-1:0];
			end
			tep_pkg::CHAR_FORM_FEED: begin
				res_byte  = tep_pkg::CHAR_NEWLINE;
				res_count = (line_ext < page_ext) ? ff_diff[15:0] : 16'd0;
				line_nxt  = '0;
			end
			default: ;
		endcase
	end

	// Advance the counters: column increments on transfer, both settle on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (in_xfer) begin
			col_q <= col_inc;
		end else if (commit) begin
			col_q  <= col_nxt;
			line_q <= line_nxt;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= in_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_byte_q  <= res_byte;
			out_count_q <= res_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign repeat_count = out_count_q;

	// A non-tab byte skips the remainder unit
	a_skip_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_byte != tep_pkg::CHAR_TAB) |=> state_q == tep_pkg::ST_FINISH)
		else $error("non-tab byte did not go straight to finish");

	// The remainder unit is never restarted mid-run
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> !rem_stat.busy)
		else $error("remainder unit started while busy");

	// Remainder completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> state_q == tep_pkg::ST_DIVIDE)
		else $error("remainder done outside divide state");

	// A result appears only after the finish state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == tep_pkg::ST_FINISH)
		else $error("output loaded outside finish state");

	// Remainder stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> rem < tab_w)
		else $error("remainder out of range");

endmodule

// File: test/tab_expand_page_fill_core_test.sv
// Testbench for tab_expand_page_fill_core: directed table, column saturation and random text.
`timescale 1ns / 1ps

module tab_expand_page_fill_core_test;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 200;
	localparam longint TIMEOUT_NS = 60_000_000;
	localparam longint unsigned COUNT_MAX = (64'd1 << tep_pkg::COUNTER_WIDTH) - 1;

	// One output run: a byte and how many times it is emitted
	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] count;
	} char_run_t;

	typedef enum logic {
		ROW_CHAR,
		ROW_REG
	} row_kind_t;

	// Directed row: a byte to send or a register to write; want is used when typed is set
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [15:0] val;
		logic        typed;
		char_run_t   want;
	} dir_row_t;

	localparam int DIR_ROWS = 35;
	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		// defaults after reset: first stop 8, width 8, page 66
		'{ROW_CHAR, '0, 16'h0041, 1'b1, '{8'h41, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd7}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd8}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd65}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd66}},
		'{ROW_CHAR, '0, 16'h00FF, 1'b1, '{8'hFF, 16'd1}},
		'{ROW_CHAR, '0, 16'h0000, 1'b1, '{8'h00, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd4}},
		'{ROW_CHAR, '0, 16'h000D, 1'b0, '0},
		'{ROW_CHAR, '0, 16'h000B, 1'b0, '0},
		// zero stops, zero width, empty page; upper data bits must be ignored
		'{ROW_REG, tep_pkg::CFG_FIRST_TAB_WIDTH, 16'hA500, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_TAB_WIDTH, 16'h5A00, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_PAGE_LENGTH, 16'h0000, 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd0}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd0}},
		// widest stops and longest page
		'{ROW_REG, tep_pkg::CFG_FIRST_TAB_WIDTH, 16'h00FF, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_TAB_WIDTH, 16'hFFFF, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_PAGE_LENGTH, 16'hFFFF, 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd254}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b1, '{tep_pkg::CHAR_SPACE, 16'd255}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b1, '{tep_pkg::CHAR_NEWLINE, 16'd1}},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b1,
			'{tep_pkg::CHAR_NEWLINE, 16'd65534}},
		// short page that the line count runs past
		'{ROW_REG, tep_pkg::CFG_FIRST_TAB_WIDTH, 16'h0003, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_TAB_WIDTH, 16'h0005, 1'b0, '0},
		'{ROW_REG, tep_pkg::CFG_PAGE_LENGTH, 16'h0002, 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_TAB), 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_NEWLINE), 1'b0, '0},
		'{ROW_CHAR, '0, 16'(tep_pkg::CHAR_FORM_FEED), 1'b0, '0},
		'{ROW_CHAR, '0, 16'h007E, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [15:0] repeat_count;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Runs awaiting their transfer on the output side, oldest first
	char_run_t pending_runs [$];

	// Predictor state and register copies
	longint unsigned col_cnt = 0;
	longint unsigned line_cnt = 0;
	logic [7:0]  stop_first = tep_pkg::RST_FIRST_TAB_WIDTH;
	logic [7:0]  stop_step = tep_pkg::RST_TAB_WIDTH;
	logic [15:0] page_len = tep_pkg::RST_PAGE_LENGTH;

	int  fail_count = 0;
	int  n_chars = 0;
	int  n_tabs = 0;
	int  n_feeds = 0;
	int  n_writes = 0;
	int  n_checked = 0;
	bit  tx_quiet = 1'b0;
	bit  hold_armed = 1'b0;

	tab_expand_page_fill_core u_dut (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint unsigned sat_sum(input longint unsigned a,
			input longint unsigned b);
		return (a + b > COUNT_MAX) ? COUNT_MAX : a + b;
	endfunction

	// Advance the column and line counters by one byte and return its run
	function automatic char_run_t expand_char(input logic [7:0] ch);
		longint unsigned step;
		longint unsigned rem;
		longint unsigned pad;
		char_run_t run;
		run.ch = ch;
		run.count = 16'd1;
		col_cnt = sat_sum(col_cnt, 1);
		case (ch)
			tep_pkg::CHAR_NEWLINE: begin
				col_cnt = 0;
				line_cnt = sat_sum(line_cnt, 1);
			end
			tep_pkg::CHAR_TAB: begin
				run.ch = tep_pkg::CHAR_SPACE;
				if (col_cnt < stop_first) begin
					pad = stop_first - col_cnt;
				end else begin
					step = (stop_step == 0) ? 1 : stop_step;
					rem = col_cnt % step;
					pad = (rem == 0) ? 0 : step - rem;
				end
				// column saturates, the count still carries the whole padding
				col_cnt = sat_sum(col_cnt, pad);
				run.count = 16'(1 + pad);
			end
			tep_pkg::CHAR_FORM_FEED: begin
				run.ch = tep_pkg::CHAR_NEWLINE;
				run.count = (line_cnt < page_len) ? 16'(page_len - line_cnt) : 16'd0;
				line_cnt = 0;
			end
			default: ;
		endcase
		return run;
	endfunction

	// Pick a register value: zero, the top, a small one or anything in range
	function automatic logic [15:0] pick_setting(input int unsigned hi);
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'(hi);
			2: return 16'($urandom_range(1, 12));
			default: return 16'($urandom_range(0, hi));
		endcase
	endfunction

	// Offer one byte after a random gap; record its run once the transfer happens
	task automatic send_char(input logic [7:0] ch, input logic typed = 1'b0,
			input char_run_t typed_run = '0);
		int gap;
		char_run_t run;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		run = expand_char(ch);
		pending_runs.push_back(typed ? typed_run : run);
		n_chars++;
		if (ch == tep_pkg::CHAR_TAB) n_tabs++;
		if (ch == tep_pkg::CHAR_FORM_FEED) n_feeds++;
		if (n_chars % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
		@(negedge clk);
	endtask

	// Write a register once the block has drained
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (pending_runs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tep_pkg::CFG_FIRST_TAB_WIDTH: stop_first = val[7:0];
			tep_pkg::CFG_TAB_WIDTH:       stop_step = val[7:0];
			tep_pkg::CFG_PAGE_LENGTH:     page_len = val;
			default: ;
		endcase
		n_writes++;
	endtask

	// Stimulus side
	initial begin : tx_side
		int i;
		int sel;
		int waited;
		logic [7:0] ch;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'd0;
		cfg_we <= 1'b0;
		cfg_index <= tep_pkg::CFG_FIRST_TAB_WIDTH;
		cfg_data <= 16'd0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_REG)
				write_reg(DIRECTED[i].idx, DIRECTED[i].val);
			else
				send_char(DIRECTED[i].val[7:0], DIRECTED[i].typed, DIRECTED[i].want);
		end

		// run the column into saturation with tabs, then count a run of lines
		write_reg(tep_pkg::CFG_FIRST_TAB_WIDTH, 16'd0);
		write_reg(tep_pkg::CFG_TAB_WIDTH, 16'd200);
		write_reg(tep_pkg::CFG_PAGE_LENGTH, 16'hFFFF);
		for (i = 0; i < 345; i++)
			send_char((i % 50 == 49) ? 8'h61 : tep_pkg::CHAR_TAB);
		for (i = 0; i < 70; i++)
			send_char(tep_pkg::CHAR_NEWLINE);
		send_char(tep_pkg::CHAR_FORM_FEED);
		send_char(tep_pkg::CHAR_FORM_FEED);

		// random text under several register settings
		for (int phase = 0; phase < 5; phase++) begin
			write_reg(tep_pkg::CFG_FIRST_TAB_WIDTH, pick_setting(255));
			write_reg(tep_pkg::CFG_TAB_WIDTH, pick_setting(255));
			write_reg(tep_pkg::CFG_PAGE_LENGTH, pick_setting(65535));
			if (phase == 0) hold_armed = 1'b1;
			repeat (110) begin
				sel = $urandom_range(0, 99);
				if (sel < 14)      ch = tep_pkg::CHAR_TAB;
				else if (sel < 24) ch = tep_pkg::CHAR_NEWLINE;
				else if (sel < 28) ch = tep_pkg::CHAR_FORM_FEED;
				else if (sel < 90) ch = 8'($urandom_range(32, 126));
				else               ch = 8'($urandom);
				send_char(ch);
			end
		end

		// drain, then give the block its latency
		in_valid <= 1'b0;
		for (waited = 0; waited < 20000 && pending_runs.size() != 0; waited++)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_runs.size() != 0) begin
			$display("%0t: %0d runs never arrived", $time, pending_runs.size());
			fail_count += pending_runs.size();
		end

		$display("Checked %0d runs from %0d bytes (%0d tabs, %0d form feeds), %0d reg writes",
			n_checked, n_chars, n_tabs, n_feeds, n_writes);
		$display("Covered column saturation, zero tab width, page overrun, %0d-cycle hold",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, one long hold, compare each transfer
	initial begin : rx_side
		int hold;
		int taken;
		bit rx_quiet;
		char_run_t want;
		taken = 0;
		rx_quiet = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = rx_quiet ? 0 : $urandom_range(0, 3);
			if (hold_armed) begin
				hold_armed = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_runs.size() == 0) begin
				$display("%0t: run %02h x%0d with none expected",
					$time, out_byte, repeat_count);
				fail_count++;
			end else begin
				want = pending_runs.pop_front();
				if (out_byte !== want.ch) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$time, want.ch, out_byte);
					fail_count++;
				end
				if (repeat_count !== want.count) begin
					$display("%0t: repeat_count expected %0d actual %0d",
						$time, want.count, repeat_count);
					fail_count++;
				end
			end
			n_checked++;
			taken++;
			if (taken % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	end

	// Stop a hung run
	initial begin : watchdog
		#TIMEOUT_NS;
		$display("%0t: timeout with %0d runs pending", $time, pending_runs.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
src/tep_pkg.sv
src/tep_rem_unit.sv
src/tab_expand_page_fill_core.sv
test/tab_expand_page_fill_core_test.sv
